/* design/gstr_pkg.sv */
// ---------------------------------------------------------------------------
// gstr_pkg: shared constants for the Gardner symbol timing recovery block
// Default widths, fixed arithmetic widths and the reciprocal used by the
// correction divide.
// ---------------------------------------------------------------------------
package gstr_pkg;

    // Default sample and phase accumulator widths
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int PHASE_BITS_DEF  = 32;

    // Fixed widths of the loop arithmetic
    localparam int STEP_BITS = 31;   // phase step register
    localparam int CORR_BITS = 32;   // signed phase correction
    localparam int FILT_BITS = 34;   // filtered error, Q4.30
    localparam int MUL_BITS  = 33;   // signed operand width of the shared multiplier
    localparam int PROD_BITS = 2 * MUL_BITS;

    // Error is held with 30 fraction bits
    localparam int ERR_FRAC  = 30;

    // Divide by 200 * 2^30 = 2^33 * 25: shift by 33, then multiply by
    // ceil(2^35 / 25) and shift by 35 (exact for quotients below 2^30)
    localparam int DIV_SHIFT   = 33;
    localparam int QUO_BITS    = 30;
    localparam int RECIP_SHIFT = 35;
    localparam int RECIP_BITS  = 31;
    localparam logic [RECIP_BITS-1:0] RECIP_25 = 31'd1374389535;

endpackage

/* design/gardner_symbol_timing_recovery.sv */
// ---------------------------------------------------------------------------
// gardner_symbol_timing_recovery: NCO driven Gardner timing recovery
// Samples the input stream at recovered symbol instants and steers the
// phase accumulator from a low-pass filtered Gardner timing error.
// ---------------------------------------------------------------------------
// A sample that does not land on a symbol point keeps the block idle, and the
// block takes the next sample in the following cycle. A sample on a symbol
// point (falling wrap of the phase accumulator top bit) is emitted at once
// and keeps the block busy in S_ERR, S_FILT, S_PROD, S_RECIP and S_CORR,
// while one shared 33x33 multiplier forms the Gardner error, the step
// times filtered error product and the divide by 200 through a reciprocal;
// the new phase correction is ready when s_tready returns. A symbol item is
// only taken when the output register is free or drains in the same cycle.
// The phase step register may be written at any time the block holds no item.
module gardner_symbol_timing_recovery #(
    parameter int SAMPLE_BITS = gstr_pkg::SAMPLE_BITS_DEF,
    parameter int PHASE_BITS  = gstr_pkg::PHASE_BITS_DEF,
    parameter int TDATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // input samples
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [TDATA_BITS-1:0]           s_tdata,    // [SAMPLE_BITS-1:0] sample
    // recovered symbols
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [TDATA_BITS-1:0]           m_tdata,    // [SAMPLE_BITS-1:0] symbol
    // phase step register write
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [gstr_pkg::STEP_BITS-1:0]  cfg_data    // phase_step
);

    localparam int SB  = SAMPLE_BITS;
    localparam int FB  = 2 * (SAMPLE_BITS - 1);
    localparam int SHR = (FB > gstr_pkg::ERR_FRAC) ? FB - gstr_pkg::ERR_FRAC : 0;
    localparam int SHL = (FB < gstr_pkg::ERR_FRAC) ? gstr_pkg::ERR_FRAC - FB : 0;
    localparam int MB  = gstr_pkg::MUL_BITS;
    localparam int PB  = gstr_pkg::PROD_BITS;
    localparam int FW  = gstr_pkg::FILT_BITS;
    localparam int CW  = gstr_pkg::CORR_BITS;
    localparam int QW  = gstr_pkg::QUO_BITS;

    // Sequencer codes
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ERR   = 3'd1;
    localparam logic [2:0] S_FILT  = 3'd2;
    localparam logic [2:0] S_PROD  = 3'd3;
    localparam logic [2:0] S_RECIP = 3'd4;
    localparam logic [2:0] S_CORR  = 3'd5;

    // State
    logic [2:0]                      state_reg, state_next;
    logic [gstr_pkg::STEP_BITS-1:0]  step_reg, step_next;
    logic [PHASE_BITS-1:0]           acc_reg, acc_next;
    logic                            prev_msb_reg, prev_msb_next;
    logic signed [CW-1:0]            corr_reg, corr_next;
    logic signed [SB-1:0]            held_reg [3];
    logic signed [SB-1:0]            held_next [3];
    logic signed [FW-1:0]            filt_reg, filt_next;
    logic signed [SB:0]              diff_reg, diff_next;
    logic signed [PB-1:0]            mul_reg, mul_next;
    logic                            out_valid_reg, out_valid_next;
    logic [SB-1:0]                   sym_reg, sym_next;

    // Datapath signals
    logic                            msb;
    logic                            fall;
    logic                            rise;
    logic                            accept;
    logic signed [SB-1:0]            sample;
    logic [CW-1:0]                   phase_sum;
    logic signed [MB-1:0]            mul_a;
    logic signed [MB-1:0]            mul_b;
    logic signed [PB-1:0]            e_full;
    logic signed [FW-1:0]            e_val;
    logic signed [FW:0]              e_minus_f;
    logic signed [FW:0]              filt_sum;
    logic [FW-1:0]                   f_abs;
    logic [QW-1:0]                   quo;
    logic [CW-2:0]                   quo_final;

    // Edge detection from the accumulator before this sample's advance
    assign msb    = acc_reg[PHASE_BITS-1];
    assign fall   = prev_msb_reg && !msb;
    assign rise   = !prev_msb_reg && msb;
    assign sample = s_tdata[SB-1:0];

    // Take a sample when idle; a symbol sample also needs room at the output
    assign s_tready  = (state_reg == S_IDLE) && (!fall || !out_valid_reg || m_tready);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TDATA_BITS'(sym_reg);

    // Advance the phase modulo 2^PHASE_BITS
    assign phase_sum = CW'(acc_reg) + CW'(step_reg) + corr_reg;

    // Scale the Gardner product to 30 fraction bits (floor on right shift)
    assign e_full    = (FB >= gstr_pkg::ERR_FRAC) ? (mul_reg >>> SHR) : (mul_reg <<< SHL);
    assign e_val     = e_full[FW-1:0];
    assign e_minus_f = {e_val[FW-1], e_val} - {filt_reg[FW-1], filt_reg};
    assign filt_sum  = $signed({filt_reg[FW-1], filt_reg}) + (e_minus_f >>> 2);

    // Magnitude of the filtered error, below 2^32
    assign f_abs = filt_reg[FW-1] ? FW'(-filt_reg) : FW'(filt_reg);

    // Product bits above 2^33, then the quotient after the reciprocal multiply
    assign quo       = mul_reg[gstr_pkg::DIV_SHIFT +: QW];
    assign quo_final = mul_reg[gstr_pkg::RECIP_SHIFT +: (CW - 1)];

    // Select the operands of the shared multiplier
    always_comb
    begin
        case (state_reg)
            S_ERR:
            begin
                mul_a = MB'(diff_reg);
                mul_b = MB'(held_reg[1]);
            end
            S_PROD:
            begin
                mul_a = $signed({1'b0, f_abs[CW-1:0]});
                mul_b = $signed({{(MB - gstr_pkg::STEP_BITS){1'b0}}, step_reg});
            end
            S_RECIP:
            begin
                mul_a = $signed({{(MB - QW){1'b0}}, quo});
                mul_b = $signed({{(MB - gstr_pkg::RECIP_BITS){1'b0}}, gstr_pkg::RECIP_25});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Next state of the loop
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        acc_next       = acc_reg;
        prev_msb_next  = prev_msb_reg;
        corr_next      = corr_reg;
        held_next      = held_reg;
        filt_next      = filt_reg;
        diff_next      = diff_reg;
        mul_next       = mul_reg;
        out_valid_next = out_valid_reg;
        sym_next       = sym_reg;

        // Drop the output item once taken
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_valid)
        begin
            step_next = cfg_data;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    prev_msb_next = msb;
                    acc_next      = phase_sum[PHASE_BITS-1:0];
                    if (fall || rise)
                    begin
                        held_next[2] = held_reg[1];
                        held_next[1] = held_reg[0];
                        held_next[0] = sample;
                    end
                    if (fall)
                    begin
                        out_valid_next = 1'b1;
                        sym_next       = sample;
                        diff_next      = {sample[SB-1], sample} - {held_reg[1][SB-1], held_reg[1]};
                        state_next     = S_ERR;
                    end
                end
            end
            S_ERR:
            begin
                mul_next   = mul_a * mul_b;
                state_next = S_FILT;
            end
            S_FILT:
            begin
                filt_next  = filt_sum[FW-1:0];
                state_next = S_PROD;
            end
            S_PROD:
            begin
                mul_next   = mul_a * mul_b;
                state_next = S_RECIP;
            end
            S_RECIP:
            begin
                mul_next   = mul_a * mul_b;
                state_next = S_CORR;
            end
            S_CORR:
            begin
                // Quotient is below 2^31, so the negated value always fits
                if (filt_reg[FW-1])
                begin
                    corr_next = $signed({1'b0, quo_final});
                end
                else
                begin
                    corr_next = -$signed({1'b0, quo_final});
                end
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and loop state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            acc_reg       <= '0;
            prev_msb_reg  <= 1'b0;
            corr_reg      <= '0;
            held_reg[0]   <= '0;
            held_reg[1]   <= '0;
            held_reg[2]   <= '0;
            filt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            acc_reg       <= acc_next;
            prev_msb_reg  <= prev_msb_next;
            corr_reg      <= corr_next;
            held_reg      <= held_next;
            filt_reg      <= filt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        diff_reg <= diff_next;
        mul_reg  <= mul_next;
        sym_reg  <= sym_next;
    end

    // Busy sequencer never takes a sample
    a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !s_tready)
        else $error("sample taken while correction update runs");

    // A symbol sample starts the update and presents a symbol
    a_symbol_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && fall) |=> (state_reg == S_ERR) && out_valid_reg)
        else $error("symbol sample did not start update or emit symbol");

    // The update returns to idle after the correction step
    a_corr_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CORR) |=> (state_reg == S_IDLE))
        else $error("sequencer did not return to idle after correction");

    // Phase only moves on an accepted sample
    a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(acc_reg))
        else $error("phase accumulator moved without a sample");

endmodule
